FILE: rtl/wbmp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the WBMP type-0 stream decoder.
// No dependencies; the files that use it refer to it by scoped names.
package wbmp_pkg;

   // Result kinds
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error causes
   localparam logic [2:0] CAUSE_BAD_TYPE    = 3'd0;
   localparam logic [2:0] CAUSE_BAD_FIX     = 3'd1;
   localparam logic [2:0] CAUSE_WIDTH_OVF   = 3'd2;
   localparam logic [2:0] CAUSE_HEIGHT_OVF  = 3'd3;
   localparam logic [2:0] CAUSE_FAILED      = 3'd4;

   localparam logic [31:0] SIZE_OVF_MASK  = 32'hFE00_0000;
   localparam logic [7:0]  FIX_HDR_MASK   = 8'h9F;
   localparam logic [7:0]  TYPE_ZERO      = 8'h00;
   localparam logic [3:0]  MAX_RUN        = 4'd8;

   // One queued command: a header, an error or a run of pixels from one byte.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [3:0]  count;
      logic [31:0] x_base;
      logic [31:0] y_row;
      logic [31:0] image_width;
      logic [31:0] image_height;
      logic [2:0]  cause;
      logic        end_of_image;
   } cmd_type;

endpackage

FILE: rtl/wbmp_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// No dependencies.
interface wbmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface wbmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        pixel_white;
   logic [31:0] pixel_x;
   logic [31:0] pixel_y;
   logic [31:0] image_width;
   logic [31:0] image_height;
   logic [2:0]  error_cause;
   logic        end_of_image;
   logic        last_of_run;

   modport source (output valid, output kind, output pixel_white, output pixel_x,
                   output pixel_y, output image_width, output image_height,
                   output error_cause, output end_of_image, output last_of_run,
                   input ready);
   modport sink   (input valid, input kind, input pixel_white, input pixel_x,
                   input pixel_y, input image_width, input image_height,
                   input error_cause, input end_of_image, input last_of_run,
                   output ready);
endinterface

FILE: rtl/wbmp_front.sv
`timescale 1ns / 1ps
// Front end: takes file bytes, tracks the header and row position, and
// queues one command per byte that yields results. Depends on wbmp_pkg and wbmp_channels.
module wbmp_front (
   input  logic               clock,
   input  logic               reset,
   wbmp_req_if.sink           req,
   input  logic               queue_full,
   output logic               push,
   output wbmp_pkg::cmd_type  push_cmd
);

   localparam logic [2:0] PH_TYPE   = 3'd0;
   localparam logic [2:0] PH_FIX    = 3'd1;
   localparam logic [2:0] PH_WIDTH  = 3'd2;
   localparam logic [2:0] PH_HEIGHT = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;
   localparam logic [2:0] PH_FAILED = 3'd6;

   logic [2:0]  phase_ff, phase_in, phase_cur;
   logic [31:0] width_ff, width_in, width_cur;
   logic [31:0] height_ff, height_in, height_cur;
   logic [31:0] col_ff, col_in, col_cur;
   logic [31:0] row_ff, row_in, row_cur;
   logic        fire;
   logic        want_push;
   logic [31:0] acc_w, acc_h, left;
   logic [3:0]  run_len;
   logic        row_end, img_end, empty;

   assign req.ready = !queue_full;
   assign fire      = req.valid && !queue_full;
   assign push      = fire && want_push;

   always_comb begin
      // A restart clears the state before this byte is parsed.
      phase_cur  = req.restart ? PH_TYPE : phase_ff;
      width_cur  = req.restart ? 32'd0 : width_ff;
      height_cur = req.restart ? 32'd0 : height_ff;
      col_cur    = req.restart ? 32'd0 : col_ff;
      row_cur    = req.restart ? 32'd0 : row_ff;

      acc_w   = {width_cur[24:0], 7'd0} + {25'd0, req.data_byte[6:0]};
      acc_h   = {height_cur[24:0], 7'd0} + {25'd0, req.data_byte[6:0]};
      left    = width_cur - col_cur;
      run_len = (left < 32'd8) ? left[3:0] : wbmp_pkg::MAX_RUN;
      row_end = (left <= 32'd8);
      img_end = row_end && ((row_cur + 32'd1) == height_cur);
      empty   = (width_cur == 32'd0) || (acc_h == 32'd0);

      phase_in  = phase_cur;
      width_in  = width_cur;
      height_in = height_cur;
      col_in    = col_cur;
      row_in    = row_cur;
      want_push = 1'b0;
      push_cmd  = '0;

      case (phase_cur)
         PH_TYPE: begin
            if (req.data_byte != wbmp_pkg::TYPE_ZERO) begin
               want_push      = 1'b1;
               push_cmd.kind  = wbmp_pkg::KIND_ERROR;
               push_cmd.cause = wbmp_pkg::CAUSE_BAD_TYPE;
               phase_in       = PH_FAILED;
            end else begin
               phase_in = PH_FIX;
            end
         end
         PH_FIX: begin
            if ((req.data_byte & wbmp_pkg::FIX_HDR_MASK) != 8'd0) begin
               want_push      = 1'b1;
               push_cmd.kind  = wbmp_pkg::KIND_ERROR;
               push_cmd.cause = wbmp_pkg::CAUSE_BAD_FIX;
               phase_in       = PH_FAILED;
            end else begin
               phase_in = PH_WIDTH;
            end
         end
         PH_WIDTH: begin
            if ((width_cur & wbmp_pkg::SIZE_OVF_MASK) != 32'd0) begin
               want_push      = 1'b1;
               push_cmd.kind  = wbmp_pkg::KIND_ERROR;
               push_cmd.cause = wbmp_pkg::CAUSE_WIDTH_OVF;
               phase_in       = PH_FAILED;
            end else begin
               width_in = acc_w;
               if (!req.data_byte[7]) begin
                  phase_in = PH_HEIGHT;
               end
            end
         end
         PH_HEIGHT: begin
            if ((height_cur & wbmp_pkg::SIZE_OVF_MASK) != 32'd0) begin
               want_push      = 1'b1;
               push_cmd.kind  = wbmp_pkg::KIND_ERROR;
               push_cmd.cause = wbmp_pkg::CAUSE_HEIGHT_OVF;
               phase_in       = PH_FAILED;
            end else begin
               height_in = acc_h;
               if (!req.data_byte[7]) begin
                  want_push             = 1'b1;
                  push_cmd.kind         = wbmp_pkg::KIND_HEADER;
                  push_cmd.image_width  = width_cur;
                  push_cmd.image_height = acc_h;
                  push_cmd.end_of_image = empty;
                  col_in                = 32'd0;
                  row_in                = 32'd0;
                  phase_in              = empty ? PH_DONE : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            want_push             = 1'b1;
            push_cmd.kind         = wbmp_pkg::KIND_PIXEL;
            push_cmd.data_byte    = req.data_byte;
            push_cmd.count        = run_len;
            push_cmd.x_base       = col_cur;
            push_cmd.y_row        = row_cur;
            push_cmd.end_of_image = img_end;
            if (row_end) begin
               col_in = 32'd0;
               row_in = row_cur + 32'd1;
               if (img_end) begin
                  phase_in = PH_DONE;
               end
            end else begin
               col_in = col_cur + {28'd0, run_len};
            end
         end
         PH_FAILED: begin
            want_push      = 1'b1;
            push_cmd.kind  = wbmp_pkg::KIND_ERROR;
            push_cmd.cause = wbmp_pkg::CAUSE_FAILED;
         end
         default: begin
            // Image done (or the unused code): the byte is dropped.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         width_ff  <= 32'd0;
         height_ff <= 32'd0;
         col_ff    <= 32'd0;
         row_ff    <= 32'd0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

FILE: rtl/wbmp_cmd_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the expander.
// Depends on wbmp_pkg for the command type.
module wbmp_cmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wbmp_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output wbmp_pkg::cmd_type  head_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   wbmp_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/wbmp_expand.sv
`timescale 1ns / 1ps
// Back end: turns the command at the queue head into result items, one per cycle while
// the output is not stalled, into a registered output stage. Depends on wbmp_pkg and wbmp_channels.
module wbmp_expand (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  wbmp_pkg::cmd_type  head_cmd,
   output logic               pop,
   wbmp_rsp_if.source         rsp
);

   logic [2:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  kind_ff;
   logic        white_ff;
   logic [31:0] x_ff, y_ff, w_ff, h_ff;
   logic [2:0]  cause_ff;
   logic        eoi_ff, last_ff;
   logic        advance, is_pixel, last;

   assign advance  = head_valid && (!out_valid_ff || rsp.ready);
   assign is_pixel = (head_cmd.kind == wbmp_pkg::KIND_PIXEL);
   // Headers and errors are single items; a pixel run ends at its count.
   assign last     = !is_pixel || (({1'b0, idx_ff} + 4'd1) == head_cmd.count);
   assign pop      = advance && last;

   always_comb begin
      idx_in = idx_ff;
      if (advance) begin
         idx_in = last ? 3'd0 : idx_ff + 3'd1;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff  <= head_cmd.kind;
         white_ff <= is_pixel && head_cmd.data_byte[3'd7 - idx_ff];
         x_ff     <= is_pixel ? head_cmd.x_base + {29'd0, idx_ff} : 32'd0;
         y_ff     <= is_pixel ? head_cmd.y_row : 32'd0;
         w_ff     <= head_cmd.image_width;
         h_ff     <= head_cmd.image_height;
         cause_ff <= head_cmd.cause;
         eoi_ff   <= head_cmd.end_of_image && last;
         last_ff  <= last;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = kind_ff;
   assign rsp.pixel_white  = white_ff;
   assign rsp.pixel_x      = x_ff;
   assign rsp.pixel_y      = y_ff;
   assign rsp.image_width  = w_ff;
   assign rsp.image_height = h_ff;
   assign rsp.error_cause  = cause_ff;
   assign rsp.end_of_image = eoi_ff;
   assign rsp.last_of_run  = last_ff;

endmodule

FILE: rtl/wbmp_type0_stream_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the WBMP type-0 stream decoder: front end, command queue and
// expander. Depends on wbmp_pkg, wbmp_channels, wbmp_front, wbmp_cmd_queue,
// wbmp_expand.
//
//   channel   direction  handshake         carries
//   req_if    in         valid/ready       data_byte, restart
//   rsp_if    out        valid/ready       kind, pixel and header fields, error
//
// The front end takes one byte per cycle while the command queue has room.
// Header bytes yield no item, but for the last height byte (a header item) and a bad
// one (an error item); a pixel byte yields one to eight items, which the expander issues
// at one per cycle while the response is not stalled, limited by its single output port.
// Reset is synchronous and active high; there is no clearing pass.
// A stalled response holds its item while the queue keeps taking bytes until it is full.
module wbmp_type0_stream_decoder_top #(
   parameter int CMD_QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   wbmp_req_if.sink   req_if,
   wbmp_rsp_if.source rsp_if
);

   logic              q_full;
   logic              q_push;
   logic              q_pop;
   logic              q_head_valid;
   wbmp_pkg::cmd_type q_push_cmd;
   wbmp_pkg::cmd_type q_head_cmd;

   wbmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .queue_full (q_full),
      .push       (q_push),
      .push_cmd   (q_push_cmd)
   );

   wbmp_cmd_queue #(
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd)
   );

   wbmp_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd),
      .pop        (q_pop),
      .rsp        (rsp_if)
   );

endmodule
